/* rtl/ntprc_pkg.sv */
package ntprc_pkg;

    localparam int FRAC_BITS = 32;
    localparam int FACTOR_W  = 34;
    localparam int TIME_W    = 64;
    localparam int TIMEOUT_W = 32;
    localparam int CFG_W     = FACTOR_W;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 136;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 168;

    localparam int MUL_STEPS = FACTOR_W;
    localparam int DIV_STEPS = TIME_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int PROD_W    = TIME_W + FACTOR_W;

    localparam logic [31:0] EPOCH_OFFSET_S = 32'd2208988800;
    localparam logic [19:0] USEC_PER_S     = 20'd1000000;

    localparam logic [FACTOR_W-1:0]  ONE_FACTOR     = FACTOR_W'(64'd1 << FRAC_BITS);
    localparam logic [FACTOR_W-1:0]  FACTOR_MAX     = '1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 32'd1000000;
    localparam logic [FACTOR_W-1:0]  FLOOR_RESET    = 34'd3865470566;
    localparam logic [FACTOR_W-1:0]  CEILING_RESET  = 34'd4724464026;

    typedef enum logic [1:0] {
        ACT_QUERY,
        ACT_REQUEST,
        ACT_REPLY,
        ACT_TIMEOUT
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK,
        STAT_NOT_WAITING,
        STAT_KISS,
        STAT_ZERO_TIME,
        STAT_REJECTED,
        STAT_TIMED_OUT,
        STAT_STILL_WAITING,
        STAT_SYNCED_FIRST
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT,
        CFG_FLOOR,
        CFG_CEILING
    } cfg_index_t;

    typedef enum logic [2:0] {
        COMMIT_NONE,
        COMMIT_REQUEST,
        COMMIT_CLEAR_WAIT,
        COMMIT_FIRST,
        COMMIT_REJECT,
        COMMIT_ACCEPT
    } commit_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_COMP,
        S_DECIDE,
        S_DIV,
        S_CHECK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    prep;
        logic    mul_step;
        logic    comp;
        logic    div_init;
        logic    div_step;
        commit_t commit;
        logic    out_load;
        status_t out_status;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    awaiting;
        logic    have_sync;
        logic    kiss;
        logic    zero_secs;
        logic    timed_out;
        logic    den_zero;
        logic    in_range;
        logic    out_busy;
    } dp_stat_t;

endpackage

/* rtl/ntprc_dp.sv */
module ntprc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ntprc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [ntprc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [ntprc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic [ntprc_pkg::IN_USER_W-1:0]     s_axis_tuser,
    input  ntprc_pkg::dp_cmd_t                  cmd,
    output ntprc_pkg::dp_stat_t                 stat,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ntprc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import ntprc_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [FACTOR_W-1:0]  floor_reg, ceiling_reg;

    action_t            act_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [7:0]         strat_reg;
    logic [31:0]        secs_reg, frac_reg;

    logic [TIME_W-1:0]   sync_local_reg, sync_server_reg, sync_comp_reg;
    logic [TIME_W-1:0]   request_local_reg, last_delay_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic                awaiting_reg, have_sync_reg;

    logic [TIME_W-1:0]   delay_reg, den_reg, ntp_reg, comp_reg;
    logic [51:0]         secs_us_reg;
    logic [19:0]         usec_reg;
    logic                timed_out_reg;

    logic [TIME_W-1:0]   mhi_reg;
    logic [FACTOR_W-1:0] mlo_reg, mbits_reg;

    logic [DIV_STEPS-1:0] dvd_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [FACTOR_W-1:0]  quo_reg;
    logic                 ovf_reg;

    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;

    logic [TIME_W-1:0]   elapsed_req;
    logic [31:0]         secs_unix;
    logic [51:0]         frac_prod;
    logic [TIME_W:0]     mul_sum;
    logic [PROD_W-1:0]   prod;
    logic [TIME_W-1:0]   num;
    logic [TIME_W:0]     trial;
    logic                fits;
    logic [FACTOR_W-1:0] q_w;
    logic [TIME_W-1:0]   clock_out;

    assign elapsed_req = now_reg - request_local_reg;
    assign secs_unix   = secs_reg - EPOCH_OFFSET_S;
    assign frac_prod   = 52'(frac_reg) * 52'(USEC_PER_S);
    assign mul_sum     = {1'b0, mhi_reg} + (mbits_reg[0] ? {1'b0, den_reg} : '0);
    assign prod        = {mhi_reg, mlo_reg};
    assign num         = (ntp_reg - sync_server_reg) - (comp_reg - ntp_reg);
    assign trial       = {rem_reg, dvd_reg[DIV_STEPS-1]};
    assign fits        = trial >= {1'b0, den_reg};
    assign q_w         = ovf_reg ? FACTOR_MAX : quo_reg;
    assign clock_out   = (sync_local_reg == now_reg) ? sync_comp_reg : comp_reg;

    always_comb begin
        stat.action    = act_reg;
        stat.awaiting  = awaiting_reg;
        stat.have_sync = have_sync_reg;
        stat.kiss      = strat_reg == 8'd0;
        stat.zero_secs = secs_reg == 32'd0;
        stat.timed_out = timed_out_reg;
        stat.den_zero  = den_reg == '0;
        stat.in_range  = (q_w >= floor_reg) && (q_w <= ceiling_reg);
        stat.out_busy  = m_tvalid_reg && !m_axis_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            floor_reg   <= FLOOR_RESET;
            ceiling_reg <= CEILING_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TIMEOUT: timeout_reg <= cfg_wdata[TIMEOUT_W-1:0];
                CFG_FLOOR:   floor_reg   <= cfg_wdata;
                CFG_CEILING: ceiling_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg   <= action_t'(s_axis_tuser);
            now_reg   <= s_axis_tdata[63:0];
            strat_reg <= s_axis_tdata[71:64];
            secs_reg  <= s_axis_tdata[103:72];
            frac_reg  <= s_axis_tdata[135:104];
        end
        if (cmd.prep) begin
            delay_reg     <= {1'b0, elapsed_req[TIME_W-1:1]};
            timed_out_reg <= awaiting_reg && (elapsed_req > TIME_W'(timeout_reg));
            den_reg       <= now_reg - sync_local_reg;
            secs_us_reg   <= 52'(secs_unix) * 52'(USEC_PER_S);
            usec_reg      <= frac_prod[51:32];
            mhi_reg       <= '0;
            mlo_reg       <= '0;
            mbits_reg     <= factor_reg;
        end
        if (cmd.mul_step) begin
            mhi_reg   <= mul_sum[TIME_W:1];
            mlo_reg   <= {mul_sum[0], mlo_reg[FACTOR_W-1:1]};
            mbits_reg <= mbits_reg >> 1;
            ntp_reg   <= TIME_W'(secs_us_reg) + TIME_W'(usec_reg) + delay_reg;
        end
        if (cmd.comp) begin
            comp_reg <= sync_comp_reg + prod[FRAC_BITS +: TIME_W];
        end
        if (cmd.div_init) begin
            dvd_reg <= {num, FRAC_BITS'(0)};
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        if (cmd.div_step) begin
            rem_reg <= fits ? TIME_W'(trial - {1'b0, den_reg}) : trial[TIME_W-1:0];
            dvd_reg <= dvd_reg << 1;
            quo_reg <= {quo_reg[FACTOR_W-2:0], fits};
            ovf_reg <= ovf_reg | quo_reg[FACTOR_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_local_reg    <= '0;
            sync_server_reg   <= '0;
            sync_comp_reg     <= '0;
            factor_reg        <= ONE_FACTOR;
            request_local_reg <= '0;
            awaiting_reg      <= 1'b0;
            have_sync_reg     <= 1'b0;
            last_delay_reg    <= '0;
        end else begin
            unique case (cmd.commit)
                COMMIT_NONE: ;
                COMMIT_REQUEST: begin
                    request_local_reg <= now_reg;
                    awaiting_reg      <= 1'b1;
                end
                COMMIT_CLEAR_WAIT: awaiting_reg <= 1'b0;
                COMMIT_FIRST: begin
                    awaiting_reg    <= 1'b0;
                    last_delay_reg  <= delay_reg;
                    sync_local_reg  <= now_reg;
                    sync_server_reg <= ntp_reg;
                    sync_comp_reg   <= ntp_reg;
                    factor_reg      <= ONE_FACTOR;
                    have_sync_reg   <= 1'b1;
                end
                COMMIT_REJECT: begin
                    awaiting_reg   <= 1'b0;
                    last_delay_reg <= delay_reg;
                end
                COMMIT_ACCEPT: begin
                    awaiting_reg    <= 1'b0;
                    last_delay_reg  <= delay_reg;
                    sync_comp_reg   <= comp_reg;
                    factor_reg      <= q_w;
                    sync_local_reg  <= now_reg;
                    sync_server_reg <= ntp_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {2'b00, have_sync_reg, last_delay_reg, factor_reg, clock_out,
                            cmd.out_status};
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    a_first_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit == COMMIT_FIRST |=> have_sync_reg && sync_local_reg == $past(now_reg))
        else $error("first sync not taken");

    a_accept_factor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit == COMMIT_ACCEPT |=> factor_reg == $past(q_w) && !awaiting_reg)
        else $error("accepted factor not stored");

    a_request_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit == COMMIT_REQUEST |=> awaiting_reg && request_local_reg == $past(now_reg))
        else $error("request not recorded");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_tvalid_reg && !m_axis_tready))
        else $error("result overwritten");

endmodule

/* rtl/ntprc_ctrl.sv */
module ntprc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  ntprc_pkg::dp_stat_t  stat,
    output ntprc_pkg::dp_cmd_t   cmd
);
    import ntprc_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    status_t           status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            status_reg <= STAT_OK;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        cmd            = '0;
        cmd.commit     = COMMIT_NONE;
        cmd.out_status = status_reg;
        s_axis_tready  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    state_next = S_COMP;
                end
            end
            S_COMP: begin
                cmd.comp   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next  = S_OUT;
                status_next = STAT_OK;
                unique case (stat.action)
                    ACT_QUERY: ;
                    ACT_REQUEST: cmd.commit = COMMIT_REQUEST;
                    ACT_TIMEOUT: begin
                        if (!stat.awaiting) begin
                            status_next = STAT_NOT_WAITING;
                        end else if (stat.timed_out) begin
                            status_next = STAT_TIMED_OUT;
                            cmd.commit  = COMMIT_CLEAR_WAIT;
                        end else begin
                            status_next = STAT_STILL_WAITING;
                        end
                    end
                    ACT_REPLY: begin
                        priority if (!stat.awaiting) begin
                            status_next = STAT_NOT_WAITING;
                        end else if (stat.kiss || stat.zero_secs) begin
                            status_next = stat.kiss ? STAT_KISS : STAT_ZERO_TIME;
                            if (stat.timed_out) begin
                                cmd.commit = COMMIT_CLEAR_WAIT;
                            end
                        end else if (!stat.have_sync) begin
                            status_next = STAT_SYNCED_FIRST;
                            cmd.commit  = COMMIT_FIRST;
                        end else if (stat.den_zero) begin
                            status_next = STAT_REJECTED;
                            cmd.commit  = COMMIT_REJECT;
                        end else begin
                            cmd.div_init = 1'b1;
                            cnt_next     = '0;
                            state_next   = S_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = S_OUT;
                if (stat.in_range) begin
                    status_next = STAT_OK;
                    cmd.commit  = COMMIT_ACCEPT;
                end else begin
                    status_next = STAT_REJECTED;
                    cmd.commit  = COMMIT_REJECT;
                end
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_mul_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL && cnt_reg == CNT_W'(MUL_STEPS - 1) |=> state_reg == S_COMP)
        else $error("multiply length wrong");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1) |=> state_reg == S_CHECK)
        else $error("divide length wrong");

    a_check_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CHECK |-> cmd.commit == COMMIT_ACCEPT || cmd.commit == COMMIT_REJECT)
        else $error("factor check without commit");

endmodule

/* rtl/ntp_rate_compensated_clock.sv */
// Every input beat runs the 34-step shift-add multiplier; a reply that estimates a
// new rate factor also runs the 96-step serial restoring divider and a check.
// One item in flight: a new input beat is taken only after the result beat of the
// previous one is loaded, and that load waits while an earlier result beat still
// waits for m_axis_tready.
// Reset: aresetn synchronous active low; clears sync state, factor to 1.0.
module ntp_rate_compensated_clock (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ntprc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [ntprc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // local_time, server_stratum, server_seconds, server_fraction
    input  logic [ntprc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action
    input  logic [ntprc_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status, clock_us, rate_factor, path_delay_us, is_synced
    output logic [ntprc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import ntprc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ntprc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    ntprc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* dv/ntprc_checker.sv */
module ntprc_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ntprc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [ntprc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [ntprc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic [ntprc_pkg::IN_USER_W-1:0]     s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [ntprc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output int                                  fail_count,
    output int                                  pending
);
    import ntprc_pkg::*;

    typedef struct packed {
        status_t              status;
        logic [TIME_W-1:0]    clock_us;
        logic [FACTOR_W-1:0]  factor;
        logic [TIME_W-1:0]    delay_us;
        logic                 synced;
    } clock_result_t;

    clock_result_t expected_q[$];

    logic [TIMEOUT_W-1:0] timeout_us;
    logic [FACTOR_W-1:0]  floor_q, ceiling_q;
    logic [TIME_W-1:0]    sync_local, sync_server, sync_comp, request_local, last_delay;
    logic [FACTOR_W-1:0]  factor;
    logic                 awaiting, synced;
    int                   mismatches;

    assign pending = expected_q.size();

    function automatic logic [TIME_W-1:0] compensated_at(input logic [TIME_W-1:0] t);
        logic [127:0] prod;
        prod = {94'b0, factor} * {64'b0, t - sync_local};
        return sync_comp + prod[95:32];
    endfunction

    function automatic logic [FACTOR_W-1:0] rate_ratio(input logic [TIME_W-1:0] num,
                                                       input logic [TIME_W-1:0] den);
        logic [95:0] q;
        if (num / den >= 64'd4)
            return FACTOR_MAX;
        q = {num, 32'b0} / {32'b0, den};
        return q[FACTOR_W-1:0];
    endfunction

    task automatic predict_step(input action_t act, input logic [IN_DATA_W-1:0] d);
        logic [TIME_W-1:0] now, secs, usec, dly, ntp, comp_now, den, num;
        logic [7:0]        stratum;
        logic [31:0]       secs_in, frac_in;
        logic [FACTOR_W-1:0] q;
        logic              timed_out;
        status_t           st;
        clock_result_t     r;
        now       = d[63:0];
        stratum   = d[71:64];
        secs_in   = d[103:72];
        frac_in   = d[135:104];
        st        = STAT_OK;
        timed_out = awaiting && (now - request_local > {32'b0, timeout_us});
        case (act)
            ACT_REQUEST: begin
                request_local = now;
                awaiting = 1'b1;
            end
            ACT_TIMEOUT: begin
                if (!awaiting) st = STAT_NOT_WAITING;
                else if (timed_out) begin
                    awaiting = 1'b0;
                    st = STAT_TIMED_OUT;
                end else st = STAT_STILL_WAITING;
            end
            ACT_REPLY: begin
                if (!awaiting) st = STAT_NOT_WAITING;
                else if (stratum == 8'd0 || secs_in == 32'd0) begin
                    st = (stratum == 8'd0) ? STAT_KISS : STAT_ZERO_TIME;
                    if (timed_out) awaiting = 1'b0;
                end else begin
                    secs = {32'b0, secs_in - EPOCH_OFFSET_S};
                    usec = ({32'b0, frac_in} * 64'd1000000) >> 32;
                    dly  = (now - request_local) >> 1;
                    ntp  = (secs + dly / 64'd1000000) * 64'd1000000 + usec + dly % 64'd1000000;
                    awaiting   = 1'b0;
                    last_delay = dly;
                    if (!synced) begin
                        sync_local  = now;
                        sync_server = ntp;
                        sync_comp   = ntp;
                        factor      = ONE_FACTOR;
                        synced      = 1'b1;
                        st          = STAT_SYNCED_FIRST;
                    end else begin
                        comp_now = compensated_at(now);
                        den = now - sync_local;
                        num = (ntp - sync_server) - (comp_now - ntp);
                        q = (den == 0) ? '0 : rate_ratio(num, den);
                        if (den == 0 || q < floor_q || q > ceiling_q) st = STAT_REJECTED;
                        else begin
                            sync_comp   = comp_now;
                            factor      = q;
                            sync_local  = now;
                            sync_server = ntp;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.status   = st;
        r.clock_us = compensated_at(now);
        r.factor   = factor;
        r.delay_us = last_delay;
        r.synced   = synced;
        expected_q.push_back(r);
    endtask

    task automatic compare_result(input logic [OUT_DATA_W-1:0] d);
        clock_result_t e, a;
        a.status   = status_t'(d[2:0]);
        a.clock_us = d[66:3];
        a.factor   = d[100:67];
        a.delay_us = d[164:101];
        a.synced   = d[165];
        if (expected_q.size() == 0) begin
            fail_count++;
            if (mismatches++ < 10) $display("unexpected result beat %h", d);
            return;
        end
        e = expected_q.pop_front();
        if (e.status !== a.status || e.clock_us !== a.clock_us || e.factor !== a.factor ||
            e.delay_us !== a.delay_us || e.synced !== a.synced) begin
            fail_count++;
            if (mismatches++ < 10)
                $display({"mismatch: exp st=%0d clk=%h fac=%h dly=%h syn=%b",
                          " / got st=%0d clk=%h fac=%h dly=%h syn=%b"},
                         e.status, e.clock_us, e.factor, e.delay_us, e.synced,
                         a.status, a.clock_us, a.factor, a.delay_us, a.synced);
        end
    endtask

    initial begin
        fail_count = 0;
        mismatches = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            timeout_us    = TIMEOUT_RESET;
            floor_q       = FLOOR_RESET;
            ceiling_q     = CEILING_RESET;
            sync_local    = '0;
            sync_server   = '0;
            sync_comp     = '0;
            factor        = ONE_FACTOR;
            request_local = '0;
            awaiting      = 1'b0;
            synced        = 1'b0;
            last_delay    = '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_TIMEOUT: timeout_us = cfg_wdata[TIMEOUT_W-1:0];
                    CFG_FLOOR:   floor_q    = cfg_wdata;
                    CFG_CEILING: ceiling_q  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_step(action_t'(s_axis_tuser), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                compare_result(m_axis_tdata);
        end
    end

endmodule

/* dv/tb.sv */
module tb;
    import ntprc_pkg::*;

    localparam int WATCHDOG = 6000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    int                    fail_count, pending;
    int                    burst_left;
    int                    idle_cycles;
    int                    rx_beats;
    logic [63:0]           lt, srv;

    ntp_rate_compensated_clock u_dut (.*);

    ntprc_checker u_chk (.*);

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver: random stalls, one long hold-off
    initial begin
        int hold;
        m_axis_tready = 1'b0;
        hold = 0;
        rx_beats = 0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) rx_beats++;
            if (rx_beats == 300 && hold == 0) begin
                m_axis_tready <= 1'b0;
                repeat (800) @(posedge aclk);
                hold = 1;
                m_axis_tready <= 1'b1;
            end else if ((rx_beats / 64) % 3 == 0)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send(input action_t act, input logic [63:0] t, input logic [7:0] stratum,
                        input logic [31:0] secs, input logic [31:0] frac);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {frac, secs, stratum, t};
        do @(posedge aclk); while (!s_axis_tready);
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 1)) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 150)) @(posedge aclk);
            end
        end
    endtask

    task automatic send_stamp(input logic [63:0] t, input logic [63:0] stamp_us);
        logic [63:0] us;
        logic [31:0] secs;
        logic [63:0] frac;
        us   = stamp_us % 64'd1000000;
        secs = 32'(stamp_us / 64'd1000000) + EPOCH_OFFSET_S;
        frac = ((us << 32) + 64'd999999) / 64'd1000000;
        send(ACT_REPLY, t, 8'($urandom_range(1, 255)), secs, frac[31:0]);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_phase(input int n);
        int k, rtt;
        logic [63:0] dt;
        longint ppm;
        for (k = 0; k < n; ) begin
            case ($urandom_range(0, 9))
                0: begin
                    send(action_t'($urandom_range(0, 3)), {$urandom, $urandom},
                         8'($urandom), $urandom, $urandom);
                    k++;
                end
                1: begin
                    send(ACT_QUERY, lt + $urandom_range(0, 100000), 0, 0, 0);
                    k++;
                end
                2: begin
                    send(ACT_REQUEST, lt, 0, 0, 0);
                    send(ACT_TIMEOUT, lt + $urandom_range(0, 3000000), 0, 0, 0);
                    k += 2;
                    if ($urandom_range(0, 1)) begin
                        send(ACT_REPLY, lt + $urandom_range(0, 3000000),
                             $urandom_range(0, 1) ? 8'd0 : 8'd3,
                             $urandom_range(0, 1) ? 32'd0 : $urandom, $urandom);
                        k++;
                    end
                end
                default: begin
                    dt  = $urandom_range(100000, 4000000);
                    ppm = longint'($urandom_range(0, 300000)) - 150000;
                    if ($urandom_range(0, 5) == 0) ppm = longint'($urandom_range(0, 400)) - 200;
                    lt  = lt + dt;
                    srv = srv + dt + 64'(longint'(dt) * ppm / 1000000);
                    rtt = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 4000000)
                                                       : $urandom_range(0, 4000);
                    send(ACT_REQUEST, lt, 0, 0, 0);
                    if ($urandom_range(0, 3) == 0) begin
                        send(ACT_TIMEOUT, lt + rtt / 2, 0, 0, 0);
                        k++;
                    end
                    send_stamp(lt + rtt, srv + rtt / 2);
                    k += 2;
                    if ($urandom_range(0, 2) == 0) begin
                        send(ACT_QUERY, lt + rtt + $urandom_range(0, 2000000), 0, 0, 0);
                        k++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        idle_cycles   = 0;
        burst_left    = 0;
        lt  = 64'd5000000;
        srv = 64'd1700000000000000 + {32'b0, $urandom};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send(ACT_QUERY, '1, 8'hff, '1, '1);
        send(ACT_TIMEOUT, 64'd0, 0, 0, 0);
        send(ACT_REPLY, lt, 8'd1, 32'd1, 32'd1);
        send(ACT_REQUEST, lt, 0, 0, 0);
        send(ACT_REPLY, lt + 10, 8'd0, '1, '1);
        send(ACT_REPLY, lt + 10, 8'hff, 32'd0, '1);
        send(ACT_TIMEOUT, lt + 1000000, 0, 0, 0);
        send(ACT_TIMEOUT, lt + 1000001, 0, 0, 0);
        send(ACT_REQUEST, lt, 0, 0, 0);
        send(ACT_REQUEST, lt + 200, 0, 0, 0);
        send(ACT_REPLY, lt + 2000000, 8'd0, 32'd5, 32'd5);
        send(ACT_TIMEOUT, lt + 2000000, 0, 0, 0);
        lt = lt + 1000;
        send(ACT_REQUEST, lt - 1000, 0, 0, 0);
        send_stamp(lt, srv);
        send(ACT_QUERY, lt, 0, 0, 0);
        send(ACT_REQUEST, lt, 0, 0, 0);
        send_stamp(lt, srv);
        send(ACT_QUERY, '1, 0, 0, 0);
        send(ACT_REQUEST, lt, 0, 0, 0);
        send(ACT_REPLY, lt, 8'd2, '1, '1);
        send(ACT_REQUEST, '1, 0, 0, 0);
        send(ACT_REPLY, lt, 8'd1, EPOCH_OFFSET_S, 32'd0);
        random_phase(450);
        drain();

        write_cfg(CFG_TIMEOUT, '0);
        write_cfg(CFG_FLOOR, '0);
        write_cfg(CFG_CEILING, '1);
        random_phase(450);
        drain();

        write_cfg(CFG_TIMEOUT, '1);
        write_cfg(CFG_FLOOR, ONE_FACTOR - 34'd50000);
        write_cfg(CFG_CEILING, ONE_FACTOR + 34'd50000);
        random_phase(450);
        drain();

        write_cfg(CFG_TIMEOUT, {2'b0, $urandom_range(1000, 3000000)});
        write_cfg(CFG_FLOOR, FLOOR_RESET);
        write_cfg(CFG_CEILING, CEILING_RESET);
        random_phase(450);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
